/* rtl/kwdt_pkg.sv */
package kwdt_pkg;

  // Input operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [11:0] KWDT_KEY       = 12'hA57;
  localparam int          EN_BIT         = 0;
  localparam int          RST_OLD_BIT    = 1;
  localparam int          RST_NEW_BIT    = 0;
  localparam int          RESTART_BIT    = 0;
  localparam logic [3:0]  INTV_ENTRIES   = 4'd12;
  localparam logic        LAYOUT_RESET   = 1'b1;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_IRQEN,
    SEL_IRQSTA,
    SEL_CTRL,
    SEL_CFG,
    SEL_MODE
  } kwdt_reg_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        offset_error;
    logic        reset_pulse;
    logic [5:0]  ticks_remaining;
  } kwdt_result_t;

  // Map a word index to a register for the given layout
  function automatic kwdt_reg_t decode_reg(input logic keyed, input logic [2:0] idx);
    kwdt_reg_t r;
    r = SEL_NONE;
    if (keyed) begin
      unique case (idx)
        3'd0, 3'd2, 3'd3: r = SEL_IRQEN;
        3'd1:             r = SEL_IRQSTA;
        3'd4:             r = SEL_CTRL;
        3'd5:             r = SEL_CFG;
        3'd6:             r = SEL_MODE;
        default:          r = SEL_NONE;
      endcase
    end else begin
      unique case (idx)
        3'd0:    r = SEL_CTRL;
        3'd1:    r = SEL_MODE;
        default: r = SEL_NONE;
      endcase
    end
    return r;
  endfunction

  // Half-second counts per interval index
  function automatic logic [5:0] load_value(input logic [3:0] intv);
    logic [5:0] v;
    v = 6'd0;
    unique case (intv)
      4'd0:    v = 6'd1;
      4'd1:    v = 6'd2;
      4'd2:    v = 6'd4;
      4'd3:    v = 6'd6;
      4'd4:    v = 6'd8;
      4'd5:    v = 6'd10;
      4'd6:    v = 6'd12;
      4'd7:    v = 6'd16;
      4'd8:    v = 6'd20;
      4'd9:    v = 6'd24;
      4'd10:   v = 6'd28;
      4'd11:   v = 6'd32;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/kwdt_if.sv */
interface kwdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  word_index;
  logic [31:0] write_data;

  modport source (output valid, mode, word_index, write_data, input ready);
  modport sink   (input valid, mode, word_index, write_data, output ready);
endinterface

interface kwdt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        offset_error;
  logic        reset_pulse;
  logic [5:0]  ticks_remaining;

  modport source (output valid, read_data, offset_error, reset_pulse, ticks_remaining,
                  input ready);
  modport sink   (input valid, read_data, offset_error, reset_pulse, ticks_remaining,
                  output ready);
endinterface

/* rtl/kwdt_core.sv */
module kwdt_core
  import kwdt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [1:0]   mode,
  input  logic [2:0]   word_index,
  input  logic [31:0]  write_data,
  input  logic         keyed,
  output kwdt_result_t result
);

  logic [31:0] mode_word_r, mode_word_nxt;
  logic [31:0] config_word_r, config_word_nxt;
  logic [31:0] irq_en_r, irq_en_nxt;
  logic [31:0] irq_sta_r, irq_sta_nxt;
  logic [5:0]  countdown_r, countdown_nxt;
  logic        counting_r, counting_nxt;

  kwdt_reg_t   reg_sel;
  logic [3:0]  intv;
  logic [5:0]  load_cnt;
  logic        do_load;
  logic        key_ok;
  logic [5:0]  dec_cnt;
  logic        rst_en;

  assign reg_sel = decode_reg(keyed, word_index);
  assign key_ok  = keyed ? (write_data[12:1] == KWDT_KEY) : 1'b1;
  assign dec_cnt = countdown_r - 6'd1;
  assign rst_en  = keyed ? config_word_r[RST_NEW_BIT] : mode_word_r[RST_OLD_BIT];

  // Interval comes from the mode word in effect after this write
  always_comb begin
    logic [31:0] src;
    src  = (reg_sel == SEL_MODE) ? write_data : mode_word_r;
    intv = keyed ? src[7:4] : src[6:3];
    load_cnt = (intv < INTV_ENTRIES) ? load_value(intv) : countdown_r;
  end

  always_comb begin
    mode_word_nxt   = mode_word_r;
    config_word_nxt = config_word_r;
    irq_en_nxt      = irq_en_r;
    irq_sta_nxt     = irq_sta_r;
    countdown_nxt   = countdown_r;
    counting_nxt    = counting_r;
    do_load         = 1'b0;
    result          = '0;

    case (mode)
      OP_READ: begin
        result.offset_error = (reg_sel == SEL_NONE);
        unique case (reg_sel)
          SEL_IRQEN:  result.read_data = irq_en_r;
          SEL_IRQSTA: result.read_data = irq_sta_r;
          SEL_CFG:    result.read_data = config_word_r;
          SEL_MODE:   result.read_data = mode_word_r;
          default:    result.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        result.offset_error = (reg_sel == SEL_NONE);
        unique case (reg_sel)
          SEL_IRQEN:  irq_en_nxt = write_data;
          SEL_IRQSTA: irq_sta_nxt = write_data;
          SEL_CFG:    config_word_nxt = write_data;
          SEL_MODE: begin
            mode_word_nxt = write_data;
            do_load = write_data[EN_BIT] & ~mode_word_r[EN_BIT];
          end
          SEL_CTRL:   do_load = key_ok & write_data[RESTART_BIT];
          default:    do_load = 1'b0;
        endcase
        if (do_load) begin
          countdown_nxt = load_cnt;
          counting_nxt  = (load_cnt != 6'd0);
        end
      end
      OP_TICK: begin
        if (counting_r && countdown_r != 6'd0) begin
          countdown_nxt = dec_cnt;
          if (dec_cnt == 6'd0) begin
            counting_nxt       = 1'b0;
            result.reset_pulse = mode_word_r[EN_BIT] & rst_en;
          end
        end else begin
          counting_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    result.ticks_remaining = countdown_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_word_r   <= '0;
      config_word_r <= '0;
      irq_en_r      <= '0;
      irq_sta_r     <= '0;
      countdown_r   <= '0;
      counting_r    <= 1'b0;
    end else if (accept) begin
      mode_word_r   <= mode_word_nxt;
      config_word_r <= config_word_nxt;
      irq_en_r      <= irq_en_nxt;
      irq_sta_r     <= irq_sta_nxt;
      countdown_r   <= countdown_nxt;
      counting_r    <= counting_nxt;
    end
  end

endmodule

/* rtl/kwdt_out_buf.sv */
module kwdt_out_buf
  import kwdt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  kwdt_result_t push_data,
  output logic         can_push,
  output logic         out_valid,
  input  logic         out_ready,
  output kwdt_result_t out_data
);

  logic         out_valid_r;
  kwdt_result_t out_data_r;
  logic         skid_valid_r;
  kwdt_result_t skid_data_r;
  logic         load_out;

  assign can_push  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load_out  = out_ready | ~out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_out) begin
      // drain the skid entry first; no new transfer comes in while it is full
      out_valid_r  <= skid_valid_r | push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end
    if (!load_out && push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

/* rtl/keyed_watchdog_timer.sv */
// Keyed watchdog timer, register-bus style.
// in_ch carries one operation per transfer: a register read, a register
// write or a half-second tick, with a word index and 32-bit write data.
// out_ch returns one result per input transfer, in order: read data,
// an offset error flag, the system reset pulse and the ticks left.
// cfg_wr_en/cfg_wr_data select the register layout (1: keyed layout,
// 0: older layout); write it only while the block is idle.
// A result is registered in the output register, or in the skid register
// when out_ch stalls. Throughput: one transfer per cycle while in_ch.ready
// is high, set by the single combinational pass between the state registers
// and the result register. A two-entry output stage (result register plus
// skid register) keeps in_ch.ready independent of out_ch.ready; in_ch.ready
// drops only after the sink has stalled with both entries full, and rises
// again as soon as the sink takes a result.
// Reset (rst_n low, synchronous) clears the core's registers and the counter,
// stops the countdown, empties the output stage and selects the keyed
// layout.
module keyed_watchdog_timer
  import kwdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  kwdt_in_if.sink    in_ch,
  kwdt_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic         layout_r;
  logic         accept;
  kwdt_result_t core_result;
  kwdt_result_t buf_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= LAYOUT_RESET;
    end else if (cfg_wr_en) begin
      layout_r <= cfg_wr_data;
    end
  end

  assign accept = in_ch.valid & in_ch.ready;

  kwdt_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .mode       (in_ch.mode),
    .word_index (in_ch.word_index),
    .write_data (in_ch.write_data),
    .keyed      (layout_r),
    .result     (core_result)
  );

  kwdt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (core_result),
    .can_push  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (buf_data)
  );

  assign out_ch.read_data       = buf_data.read_data;
  assign out_ch.offset_error    = buf_data.offset_error;
  assign out_ch.reset_pulse     = buf_data.reset_pulse;
  assign out_ch.ticks_remaining = buf_data.ticks_remaining;

endmodule

/* rtl/kwdt_checker.sv */
module kwdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        offset_error,
  input logic        reset_pulse,
  input logic [5:0]  ticks_remaining
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_data) &&
      $stable(offset_error) && $stable(reset_pulse) && $stable(ticks_remaining)))
    else $error("stalled result changed");

  // a transfer into an empty output stage shows up next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> out_valid)
    else $error("accepted item did not reach the output");

  a_pulse_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && reset_pulse) |-> (ticks_remaining == 6'd0 && !offset_error &&
      read_data == 32'd0))
    else $error("reset pulse without expiry");

  a_err_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && offset_error) |-> (read_data == 32'd0 && !reset_pulse))
    else $error("offset error with data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("output stage not empty after reset");

endmodule

bind keyed_watchdog_timer kwdt_checker u_kwdt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .read_data       (out_ch.read_data),
  .offset_error    (out_ch.offset_error),
  .reset_pulse     (out_ch.reset_pulse),
  .ticks_remaining (out_ch.ticks_remaining)
);
